@@ rtl/ppi_pkg.sv @@
`default_nettype none
package ppi_pkg;

	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_POSE    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [1:0] REG_START_X       = 2'd0;
	localparam logic [1:0] REG_START_Y       = 2'd1;
	localparam logic [1:0] REG_START_HEADING = 2'd2;

	localparam logic [16:0] RAD_STEP  = 17'd102944;
	localparam logic [17:0] TURN_GAIN = 18'd166886;
	localparam logic [17:0] DT_LIMIT  = 18'd131072;
	localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

	typedef struct packed {
		logic [1:0]          kind;
		logic                command_valid;
		logic signed [15:0]  translation_velocity;
		logic signed [15:0]  rotation_velocity;
		logic [17:0]         elapsed_time;
		logic signed [31:0]  new_x;
		logic signed [31:0]  new_y;
		logic [15:0]         new_heading;
	} item_t;

	typedef enum logic [2:0] {
		MS_NONE, MS_WDT, MS_GAIN, MS_VDT, MS_VDT_C, MS_VDT_S, MS_NUM_X, MS_NUM_Y
	} mul_sel_t;

	typedef struct packed {
		logic     accept;
		mul_sel_t mul_sel;
		logic     step_load;
		logic     turn;
		logic     sc_start;
		logic     sc_h1;
		logic     sc_capture;
		logic     div_start;
		logic     add_x_line;
		logic     add_y_line;
		logic     add_x_arc;
		logic     add_y_arc;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic v_zero;
		logic w_zero;
		logic sc_done;
		logic div_done;
	} stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_WDT, S_GAIN, S_STEP, S_DECIDE, S_SC0_WAIT, S_SC1_GO, S_SC1_WAIT,
		S_ST_VDT, S_ST_CX, S_ST_SX, S_ST_FY, S_ARC_NX, S_DIVX_GO, S_DIVX_WAIT,
		S_ARC_NY, S_DIVY_GO, S_DIVY_WAIT, S_FIN
	} state_t;

	// series term divisors and floor(2^32 / divisor)
	function automatic logic [15:0] div_const(input logic [2:0] j);
		logic [15:0] c;
		case (j)
			3'd0: c = 16'd6;
			3'd1: c = 16'd120;
			3'd2: c = 16'd5040;
			3'd3: c = 16'd24;
			3'd4: c = 16'd720;
			default: c = 16'd40320;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] div_recip(input logic [2:0] j);
		logic [31:0] m;
		case (j)
			3'd0: m = 32'd715827882;
			3'd1: m = 32'd35791394;
			3'd2: m = 32'd852176;
			3'd3: m = 32'd178956970;
			3'd4: m = 32'd5965232;
			default: m = 32'd106522;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

@@ rtl/ppi_sincos.sv @@
`default_nettype none
module ppi_sincos import ppi_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [15:0]        angle,
	output logic                    done,
	output logic signed [31:0]      sine,
	output logic signed [31:0]      cosine
);

	localparam logic [4:0] STEP_LAST = 5'd20;

	logic busy_q, done_q, swap_q;
	logic [4:0] cnt_q;
	logic [1:0] quad_q;
	logic [13:0] a_q, f;
	logic [29:0] r_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q, p8_q, q_q;
	logic signed [31:0] acc_s_q, acc_c_q, sine_q, cos_q, so, co;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [4:0] jd;
	logic [2:0] j;
	logic [29:0] x, rem, term;
	logic [15:0] dc;
	logic [45:0] qc;

	always_comb begin
		f = angle[13:0];
		jd = cnt_q - 5'd8;
		j = jd[3:1];
		case (j)
			3'd0: x = p3_q;
			3'd1: x = p5_q;
			3'd2: x = p7_q;
			3'd3: x = p4_q;
			3'd4: x = p6_q;
			default: x = p8_q;
		endcase
		dc = div_const(j);
		case (cnt_q)
			5'd0: begin mul_a = {18'b0, a_q}; mul_b = {15'b0, RAD_STEP}; end
			5'd1: begin mul_a = {2'b0, r_q}; mul_b = {2'b0, r_q}; end
			5'd2: begin mul_a = {2'b0, p2_q}; mul_b = {2'b0, r_q}; end
			5'd3: begin mul_a = {2'b0, p2_q}; mul_b = {2'b0, p2_q}; end
			5'd4: begin mul_a = {2'b0, p4_q}; mul_b = {2'b0, r_q}; end
			5'd5: begin mul_a = {2'b0, p4_q}; mul_b = {2'b0, p2_q}; end
			5'd6: begin mul_a = {2'b0, p6_q}; mul_b = {2'b0, r_q}; end
			5'd7: begin mul_a = {2'b0, p4_q}; mul_b = {2'b0, p4_q}; end
			default: begin mul_a = {2'b0, x}; mul_b = div_recip(j); end
		endcase
		prod = {32'b0, mul_a} * {32'b0, mul_b};
		qc = {16'b0, q_q} * {30'b0, dc};
		rem = x - qc[29:0];
		term = q_q + {29'b0, (rem >= {14'b0, dc})};
		so = swap_q ? acc_c_q : acc_s_q;
		co = swap_q ? acc_s_q : acc_c_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= angle[15:14];
			swap_q <= (f > 14'd8192);
			a_q <= (f > 14'd8192) ? 14'(15'd16384 - {1'b0, f}) : f;
		end
		if (busy_q) begin
			case (cnt_q)
				5'd0: r_q <= prod[29:0];
				5'd1: p2_q <= prod[59:30];
				5'd2: p3_q <= prod[59:30];
				5'd3: p4_q <= prod[59:30];
				5'd4: p5_q <= prod[59:30];
				5'd5: p6_q <= prod[59:30];
				5'd6: p7_q <= prod[59:30];
				5'd7: p8_q <= prod[59:30];
				STEP_LAST: begin
					case (quad_q)
						2'd0: begin sine_q <= so; cos_q <= co; end
						2'd1: begin sine_q <= co; cos_q <= -so; end
						2'd2: begin sine_q <= -so; cos_q <= -co; end
						default: begin sine_q <= -co; cos_q <= so; end
					endcase
				end
				default: begin
					if (!cnt_q[0]) begin
						q_q <= prod[61:32];
						if (cnt_q == 5'd8) begin
							acc_s_q <= signed'({2'b0, r_q});
							acc_c_q <= Q30_ONE - signed'({3'b0, p2_q[29:1]});
						end
					end else begin
						case (j)
							3'd0: acc_s_q <= acc_s_q - signed'({2'b0, term});
							3'd1: acc_s_q <= acc_s_q + signed'({2'b0, term});
							3'd2: acc_s_q <= acc_s_q - signed'({2'b0, term});
							3'd3: acc_c_q <= acc_c_q + signed'({2'b0, term});
							3'd4: acc_c_q <= acc_c_q - signed'({2'b0, term});
							default: acc_c_q <= acc_c_q + signed'({2'b0, term});
						endcase
					end
				end
			endcase
		end
	end

	assign done = done_q;
	assign sine = sine_q;
	assign cosine = cos_q;

endmodule
`default_nettype wire

@@ rtl/ppi_divider.sv @@
`default_nettype none
module ppi_divider import ppi_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [47:0] num,
	input  wire logic signed [29:0] den,
	output logic                    done,
	output logic [31:0]             quot
);

	localparam logic [5:0] ITER = 6'd48;

	logic busy_q, done_q, neg_q;
	logic [5:0] cnt_q;
	logic [47:0] nq_q, nmag;
	logic [29:0] rem_q, dmag_q, dmag;
	logic [30:0] rem_sh;
	logic fits;
	logic [31:0] quot_q;

	always_comb begin
		nmag = num[47] ? 48'(-num) : 48'(num);
		dmag = den[29] ? 30'(-den) : 30'(den);
		rem_sh = {rem_q, nq_q[47]};
		fits = (rem_sh >= {1'b0, dmag_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == ITER) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q <= nmag;
			dmag_q <= dmag;
			rem_q <= '0;
			neg_q <= num[47] ^ den[29];
		end else if (busy_q) begin
			if (cnt_q == ITER) begin
				quot_q <= neg_q ? -nq_q[31:0] : nq_q[31:0];
			end else begin
				rem_q <= fits ? 30'(rem_sh - {1'b0, dmag_q}) : rem_sh[29:0];
				nq_q <= {nq_q[46:0], fits};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

@@ rtl/ppi_datapath.sv @@
`default_nettype none
module ppi_datapath import ppi_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output stat_t                   stat,
	input  wire item_t              item,
	input  wire logic signed [31:0] start_x,
	input  wire logic signed [31:0] start_y,
	input  wire logic [15:0]        start_heading,
	output logic signed [31:0]      pose_x,
	output logic signed [31:0]      pose_y,
	output logic [15:0]             pose_heading
);

	logic signed [31:0] pos_x_q, pos_y_q, s0_q, c0_q, sc_sine, sc_cos;
	logic [15:0] head_q, d_q, h1, dmag;
	logic signed [15:0] held_v_q, held_w_q;
	logic [17:0] dt_q;
	logic signed [69:0] prod_q, prod, mag, shifted;
	logic signed [34:0] mul_a, mul_b, vdt_q;
	logic signed [32:0] dsx, dcy;
	logic [63:0] rnd;
	logic [31:0] line_d, div_q;
	logic p_neg_q, sc_done, div_done;
	logic signed [31:0] out_x_q, out_y_q;
	logic [15:0] out_h_q;

	always_comb begin
		h1 = head_q + d_q;
		dsx = {sc_sine[31], sc_sine} - {s0_q[31], s0_q};
		dcy = {c0_q[31], c0_q} - {sc_cos[31], sc_cos};
		mag = prod_q[69] ? -prod_q : prod_q;
		case (cmd.mul_sel)
			MS_WDT: begin mul_a = 35'(held_w_q); mul_b = signed'({17'b0, dt_q}); end
			MS_GAIN: begin
				mul_a = signed'({2'b0, mag[32:0]});
				mul_b = signed'({17'b0, TURN_GAIN});
			end
			MS_VDT: begin mul_a = 35'(held_v_q); mul_b = signed'({17'b0, dt_q}); end
			MS_VDT_C: begin mul_a = prod_q[34:0]; mul_b = 35'(c0_q); end
			MS_VDT_S: begin mul_a = vdt_q; mul_b = 35'(s0_q); end
			MS_NUM_X: begin mul_a = 35'(held_v_q); mul_b = 35'(dsx); end
			MS_NUM_Y: begin mul_a = 35'(held_v_q); mul_b = 35'(dcy); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod = mul_a * mul_b;
		rnd = prod_q[63:0] + 64'h8000_0000;
		dmag = rnd[47:32];
		shifted = prod_q >>> 42;
		line_d = shifted[31:0] + {31'b0, prod_q[69] & (|prod_q[41:0])};
		stat.v_zero = (held_v_q == '0);
		stat.w_zero = (held_w_q == '0);
		stat.sc_done = sc_done;
		stat.div_done = div_done;
	end

	ppi_sincos u_sincos (
		.clk(clk), .arst_n(arst_n), .start(cmd.sc_start),
		.angle(cmd.sc_h1 ? h1 : head_q),
		.done(sc_done), .sine(sc_sine), .cosine(sc_cos)
	);

	ppi_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(prod_q[47:0]), .den({held_w_q, 14'b0}),
		.done(div_done), .quot(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q <= '0;
			held_v_q <= '0;
			held_w_q <= '0;
		end else begin
			if (cmd.accept) begin
				case (item.kind)
					KIND_TICK: begin
						if (item.command_valid) begin
							held_v_q <= item.translation_velocity;
							held_w_q <= item.rotation_velocity;
						end
					end
					KIND_POSE: begin
						pos_x_q <= item.new_x;
						pos_y_q <= item.new_y;
						head_q <= item.new_heading;
					end
					KIND_RESTART: begin
						pos_x_q <= start_x;
						pos_y_q <= start_y;
						head_q <= start_heading;
						held_v_q <= '0;
						held_w_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.turn) head_q <= h1;
			if (cmd.add_x_line) pos_x_q <= pos_x_q + line_d;
			if (cmd.add_y_line) pos_y_q <= pos_y_q + line_d;
			if (cmd.add_x_arc) pos_x_q <= pos_x_q + div_q;
			if (cmd.add_y_arc) begin
				pos_y_q <= pos_y_q + div_q;
				head_q <= h1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) dt_q <= (item.elapsed_time > DT_LIMIT) ? '0 : item.elapsed_time;
		if (cmd.mul_sel != MS_NONE) prod_q <= prod;
		if (cmd.mul_sel == MS_GAIN) p_neg_q <= prod_q[69];
		if (cmd.mul_sel == MS_VDT_C) vdt_q <= prod_q[34:0];
		if (cmd.step_load) d_q <= p_neg_q ? -dmag : dmag;
		if (cmd.sc_capture) begin
			s0_q <= sc_sine;
			c0_q <= sc_cos;
		end
		if (cmd.out_load) begin
			out_x_q <= pos_x_q;
			out_y_q <= pos_y_q;
			out_h_q <= head_q;
		end
	end

	assign pose_x = out_x_q;
	assign pose_y = out_y_q;
	assign pose_heading = out_h_q;

endmodule
`default_nettype wire

@@ rtl/ppi_ctrl.sv @@
`default_nettype none
module ppi_ctrl import ppi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [1:0] kind,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output cmd_t            cmd,
	input  wire stat_t      stat
);

	state_t state_q, state_d;
	logic m_tvalid_q;
	logic out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_tvalid) state_d = (kind == KIND_TICK) ? S_WDT : S_FIN;
			S_WDT: state_d = S_GAIN;
			S_GAIN: state_d = S_STEP;
			S_STEP: state_d = S_DECIDE;
			S_DECIDE: state_d = stat.v_zero ? S_FIN : S_SC0_WAIT;
			S_SC0_WAIT: if (stat.sc_done) state_d = stat.w_zero ? S_ST_VDT : S_SC1_GO;
			S_SC1_GO: state_d = S_SC1_WAIT;
			S_SC1_WAIT: if (stat.sc_done) state_d = S_ARC_NX;
			S_ST_VDT: state_d = S_ST_CX;
			S_ST_CX: state_d = S_ST_SX;
			S_ST_SX: state_d = S_ST_FY;
			S_ST_FY: state_d = S_FIN;
			S_ARC_NX: state_d = S_DIVX_GO;
			S_DIVX_GO: state_d = S_DIVX_WAIT;
			S_DIVX_WAIT: if (stat.div_done) state_d = S_ARC_NY;
			S_ARC_NY: state_d = S_DIVY_GO;
			S_DIVY_GO: state_d = S_DIVY_WAIT;
			S_DIVY_WAIT: if (stat.div_done) state_d = S_FIN;
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.accept = s_tvalid;
			end
			S_WDT: cmd.mul_sel = MS_WDT;
			S_GAIN: cmd.mul_sel = MS_GAIN;
			S_STEP: cmd.step_load = 1'b1;
			S_DECIDE: begin
				cmd.turn = stat.v_zero;
				cmd.sc_start = !stat.v_zero;
			end
			S_SC0_WAIT: cmd.sc_capture = stat.sc_done;
			S_SC1_GO: begin
				cmd.sc_start = 1'b1;
				cmd.sc_h1 = 1'b1;
			end
			S_ST_VDT: cmd.mul_sel = MS_VDT;
			S_ST_CX: cmd.mul_sel = MS_VDT_C;
			S_ST_SX: begin
				cmd.add_x_line = 1'b1;
				cmd.mul_sel = MS_VDT_S;
			end
			S_ST_FY: cmd.add_y_line = 1'b1;
			S_ARC_NX: cmd.mul_sel = MS_NUM_X;
			S_DIVX_GO: cmd.div_start = 1'b1;
			S_DIVX_WAIT: cmd.add_x_arc = stat.div_done;
			S_ARC_NY: cmd.mul_sel = MS_NUM_Y;
			S_DIVY_GO: cmd.div_start = 1'b1;
			S_DIVY_WAIT: cmd.add_y_arc = stat.div_done;
			S_FIN: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

@@ rtl/planar_pose_integrator_top.sv @@
// Planar pose integrator: keeps x, y (Q16.16 m) and heading (1/65536 turn)
// and a held velocity command (Q4.12). Each input beat is a motion tick, a
// pose overwrite or a restart from the start registers, and each returns one
// pose beat. Overwrite, restart and point turns use no sin/cos or division; a
// straight move is bounded by the 21-step sin/cos sequence; an arc by two
// sin/cos runs and two 48-step serial divisions.
// One beat is worked at a time; the next is taken while the result waits.
`default_nettype none
module planar_pose_integrator_top import ppi_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// command_valid, translation_velocity, rotation_velocity, elapsed_time,
	// new_x, new_y, new_heading, zero fill
	input  wire logic [135:0] s_tdata,
	// kind
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pose_x, pose_y, pose_heading
	output logic [79:0]       m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic signed [31:0] start_x_q, start_y_q, pose_x, pose_y;
	logic [15:0] start_h_q, pose_heading;
	item_t item;
	cmd_t cmd;
	stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_h_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_START_X: start_x_q <= pwdata;
				REG_START_Y: start_y_q <= pwdata;
				REG_START_HEADING: start_h_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START_X: prdata = start_x_q;
			REG_START_Y: prdata = start_y_q;
			REG_START_HEADING: prdata = {16'b0, start_h_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		item.kind = s_tuser;
		item.command_valid = s_tdata[0];
		item.translation_velocity = s_tdata[16:1];
		item.rotation_velocity = s_tdata[32:17];
		item.elapsed_time = s_tdata[50:33];
		item.new_x = s_tdata[82:51];
		item.new_y = s_tdata[114:83];
		item.new_heading = s_tdata[130:115];
	end

	ppi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .kind(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.cmd(cmd), .stat(stat)
	);

	ppi_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .item(item),
		.start_x(start_x_q), .start_y(start_y_q), .start_heading(start_h_q),
		.pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading)
	);

	assign m_tdata = {pose_heading, pose_y, pose_x};

endmodule
`default_nettype wire
